// File: design/p16f32_pkg.sv
// ----------------------------------------------------------------------------
// p16f32_pkg
// Shared types and constants for the PCM16 / float32 converter.
// ----------------------------------------------------------------------------
package p16f32_pkg;

    localparam logic       OP_TO_FLOAT  = 1'b0;
    localparam logic       OP_TO_SAMPLE = 1'b1;
    localparam logic [7:0] EXP_BIAS     = 8'd127;
    localparam logic [7:0] EXP_MAX      = 8'd255;
    localparam logic [30:0] LIMIT_MAG   = 31'h3F7FFDF8;

    typedef struct packed {
        logic        op;
        logic [15:0] sample_in;
        logic [31:0] float_in;
    } t_in;

    typedef struct packed {
        logic [31:0] float_out;
        logic [15:0] sample_out;
    } t_out;

    // Stage 1 to stage 2 work item
    typedef struct packed {
        logic        op;
        logic        sign;
        logic        zero;     // result forced to zero
        logic [15:0] mag;      // to float: magnitude 1..32768
        logic [4:0]  lz;       // to float: leading zeros of mag
        logic [23:0] mant;     // to sample: mantissa with hidden bit
        logic [4:0]  shift;    // to sample: right shift, < 32
    } t_mid;

endpackage

// File: design/p16f32_if.sv
// ----------------------------------------------------------------------------
// p16f32_if
// Valid/ready stream channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface p16f32_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/p16f32_decode.sv
// ----------------------------------------------------------------------------
// p16f32_decode
// Stage 1: magnitude, leading-zero count, float clamp and shift amount.
// ----------------------------------------------------------------------------
module p16f32_decode (
    input  p16f32_pkg::t_in  i_in,
    output p16f32_pkg::t_mid o_mid
);
    import p16f32_pkg::*;

    logic [15:0] mag;
    logic [4:0]  lz;
    logic        neg;
    logic [30:0] fmag;
    logic        fsign;
    logic [7:0]  e;
    logic [8:0]  sh;

    always_comb begin
        neg = i_in.sample_in[15];
        mag = neg ? (16'd0 - i_in.sample_in) : i_in.sample_in;
        lz  = 5'd16;
        for (int k = 0; k < 16; k++) begin
            if (mag[k]) lz = 5'(15 - k);
        end
        fsign = i_in.float_in[31];
        fmag  = i_in.float_in[30:0];
        if (fmag[30:23] == EXP_MAX && fmag[22:0] != 23'd0) begin
            fsign = 1'b0;
            fmag  = LIMIT_MAG;
        end else if (fmag > LIMIT_MAG) begin
            fmag = LIMIT_MAG;
        end
        e  = fmag[30:23];
        sh = 9'd135 - {1'b0, e};
        o_mid.op    = i_in.op;
        o_mid.mag   = mag;
        o_mid.lz    = lz;
        o_mid.mant  = {1'b1, fmag[22:0]};
        o_mid.shift = sh[4:0];
        if (i_in.op == OP_TO_FLOAT) begin
            o_mid.sign = neg;
            o_mid.zero = (i_in.sample_in == 16'd0);
        end else begin
            o_mid.sign = fsign;
            o_mid.zero = (e == 8'd0) || (sh >= 9'd32);
        end
    end
endmodule

// File: design/p16f32_pack.sv
// ----------------------------------------------------------------------------
// p16f32_pack
// Stage 2: normalizing / denormalizing shift and result packing.
// ----------------------------------------------------------------------------
module p16f32_pack (
    input  p16f32_pkg::t_mid i_mid,
    output p16f32_pkg::t_out o_out
);
    import p16f32_pkg::*;

    logic [15:0] norm;
    logic [7:0]  ex;
    logic [23:0] v;

    always_comb begin
        norm = i_mid.mag << i_mid.lz;
        ex   = EXP_BIAS - {3'd0, i_mid.lz};
        v    = i_mid.mant >> i_mid.shift;
        o_out = '0;
        if (i_mid.zero) begin
            o_out = '0;
        end else if (i_mid.op == OP_TO_FLOAT) begin
            o_out.float_out = {i_mid.sign, ex, norm[14:0], 8'd0};
        end else begin
            o_out.sample_out = i_mid.sign ? (16'd0 - v[15:0]) : v[15:0];
        end
    end
endmodule

// File: design/pcm16_float32_converter.sv
// ----------------------------------------------------------------------------
// pcm16_float32_converter
// Converts audio samples between signed 16-bit PCM and IEEE single floats.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  (sink):   op, sample_in, float_in. op 0 turns the sample into the
//                   float bits of sample/32768; op 1 turns a float into a
//                   sample clamped to +-0.999969 and truncated toward zero.
//   o_out (source): float_out, sample_out; the unused field reads zero.
//   Three register stages: input register, decode (leading-zero count,
//   clamp, shift amount), shift/pack into the output register. The result
//   passes through the input, decode and output registers in turn before
//   o_out.valid rises. One item per cycle sustained while the receiver
//   does not stall, set by the stage registers.
//   Each stage carries a valid bit and advances when its next stage is
//   free, so a receiver stall fills the pipe and then drops i_in.ready;
//   nothing is lost or repeated. Synchronous reset clears the valid bits.
// ----------------------------------------------------------------------------
module pcm16_float32_converter (
    input  logic      i_clk,
    input  logic      i_rst_n,
    p16f32_if.sink    i_in,
    p16f32_if.source  o_out
);
    import p16f32_pkg::*;

    t_in  r_s1;
    t_mid r_s2, n_s2;
    t_out r_s3, n_s3;
    logic r_v1, r_v2, r_v3;
    logic adv3, adv2, adv1;

    // stage enables: a stage moves if the one after is empty or moving
    assign adv3 = !r_v3 || o_out.ready;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;
    assign i_in.ready = adv1;

    p16f32_decode u_dec (.i_in(r_s1), .o_mid(n_s2));
    p16f32_pack   u_pck (.i_mid(r_s2), .o_out(n_s3));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_in.valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
        end
        if (adv1) r_s1 <= i_in.data;
        if (adv2) r_s2 <= n_s2;
        if (adv3) r_s3 <= n_s3;
    end

    assign o_out.valid = r_v3;
    assign o_out.data  = r_s3;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !o_out.ready |=> r_v3 && $stable(r_s3))
        else $error("output changed during stall");
    a_full_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && r_v2 && r_v3 && !o_out.ready |-> !i_in.ready)
        else $error("accepted into full pipe");
    a_one_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> (r_s3.float_out == 32'd0 || r_s3.sample_out == 16'd0))
        else $error("both result fields nonzero");
endmodule
